### src/dcb_pkg.sv
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared types, constants and microcode for the descriptor chain builder.
// ----------------------------------------------------------------------------
package dcb_pkg;

	localparam int unsigned DEF_MAX_DESCS   = 64;
	localparam int unsigned DEF_CHUNK_BYTES = 262144;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned SIZE_W = 24;
	localparam int unsigned WC_W   = 17;

	localparam logic [15:0] ATTR_VALID = 16'h8000;
	localparam logic [15:0] ATTR_CONT  = 16'h4000;

	localparam logic [2:0] ALIGN_64   = 3'h7;
	localparam logic [2:0] ALIGN_32   = 3'h5;
	localparam logic [2:0] ALIGN_16   = 3'h3;
	localparam logic [2:0] ALIGN_NONE = 3'h0;

	localparam logic CFG_HEAD_BOUNCE = 1'b0;
	localparam logic CFG_TAIL_BOUNCE = 1'b1;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_MISALIGN = 2'd1,
		STS_TOO_MANY = 2'd2
	} status_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_LOAD  = 4'd0;
	localparam step_t ST_CHKZ  = 4'd1;
	localparam step_t ST_CHKA  = 4'd2;
	localparam step_t ST_TAIL  = 4'd3;
	localparam step_t ST_LIMIT = 4'd4;
	localparam step_t ST_HEAD  = 4'd5;
	localparam step_t ST_MID   = 4'd6;
	localparam step_t ST_TAILD = 4'd7;
	localparam step_t ST_DONE  = 4'd8;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_NOP,
		OP_HEAD,
		OP_TAIL,
		OP_LIMIT,
		OP_EMIT_HEAD,
		OP_EMIT_MID,
		OP_EMIT_TAIL,
		OP_EMIT_DONE
	} op_t;

	typedef enum logic [2:0] {
		CD_NEXT,
		CD_ALWAYS,
		CD_WAIT_IN,
		CD_SIZE_ZERO,
		CD_MISALIGNED,
		CD_OVER,
		CD_MID_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic size_zero;
		logic misaligned;
		logic over;
		logic mid_more;
		logic blocked;
	} dp_flags_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} dp_ctrl_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			ST_LOAD:  w = '{op: OP_LOAD,      cond: CD_WAIT_IN,    target: ST_LOAD};
			ST_CHKZ:  w = '{op: OP_NOP,       cond: CD_SIZE_ZERO,  target: ST_DONE};
			ST_CHKA:  w = '{op: OP_HEAD,      cond: CD_MISALIGNED, target: ST_DONE};
			ST_TAIL:  w = '{op: OP_TAIL,      cond: CD_NEXT,       target: ST_LOAD};
			ST_LIMIT: w = '{op: OP_LIMIT,     cond: CD_OVER,       target: ST_DONE};
			ST_HEAD:  w = '{op: OP_EMIT_HEAD, cond: CD_NEXT,       target: ST_LOAD};
			ST_MID:   w = '{op: OP_EMIT_MID,  cond: CD_MID_MORE,   target: ST_MID};
			ST_TAILD: w = '{op: OP_EMIT_TAIL, cond: CD_NEXT,       target: ST_LOAD};
			ST_DONE:  w = '{op: OP_EMIT_DONE, cond: CD_ALWAYS,     target: ST_LOAD};
			default:  w = '{op: OP_NOP,       cond: CD_ALWAYS,     target: ST_LOAD};
		endcase
		return w;
	endfunction

	function automatic logic [2:0] align_code(input logic [SIZE_W-1:0] bytes);
		logic [2:0] c;
		priority if (bytes[5:0] == 6'd0) begin
			c = ALIGN_64;
		end else if (bytes[4:0] == 5'd0) begin
			c = ALIGN_32;
		end else if (bytes[3:0] == 4'd0) begin
			c = ALIGN_16;
		end else begin
			c = ALIGN_NONE;
		end
		return c;
	endfunction

endpackage

### src/dcb_seq.sv
// ----------------------------------------------------------------------------
// dcb_seq
// Microcode sequencer: step counter, control word rom, conditional jumps.
// ----------------------------------------------------------------------------
module dcb_seq
	import dcb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dp_flags_t flags,
	output dp_ctrl_t  ctrl
);

	step_t  upc_q;
	ucode_t uw;
	logic   taken;
	logic   go;

	assign uw = ucode_rom(upc_q);
	assign go = !flags.blocked;

	always_comb begin
		unique case (uw.cond)
			CD_NEXT:       taken = 1'b0;
			CD_ALWAYS:     taken = 1'b1;
			CD_WAIT_IN:    taken = !flags.in_valid;
			CD_SIZE_ZERO:  taken = flags.size_zero;
			CD_MISALIGNED: taken = flags.misaligned;
			CD_OVER:       taken = flags.over;
			CD_MID_MORE:   taken = flags.mid_more;
			default:       taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_LOAD;
		end else if (go) begin
			upc_q <= taken ? uw.target : upc_q + 4'd1;
		end
	end

	assign ctrl.op = uw.op;
	assign ctrl.go = go;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		flags.blocked |=> upc_q == $past(upc_q))
		else $error("step advanced while output blocked");

	a_wait_in: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == ST_LOAD && !flags.in_valid) |=> upc_q == ST_LOAD)
		else $error("left load step without a transaction");

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= ST_DONE)
		else $error("step counter out of range");

endmodule

### src/dcb_dpath.sv
// ----------------------------------------------------------------------------
// dcb_dpath
// Datapath: request registers, chain split arithmetic, output register.
// ----------------------------------------------------------------------------
module dcb_dpath
	import dcb_pkg::*;
#(
	parameter int unsigned MAX_DESCS   = DEF_MAX_DESCS,
	parameter int unsigned CHUNK_BYTES = DEF_CHUNK_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_ctrl_t            ctrl,
	output dp_flags_t           flags,
	input  logic                cfg_we,
	input  logic                cfg_sel,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         buffer_addr,
	input  logic [SIZE_W-1:0]   byte_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [IDX_W-1:0]    desc_index,
	output logic [31:0]         target_addr,
	output logic [WC_W-1:0]     word_count,
	output logic [15:0]         attr_word,
	output logic [1:0]          status,
	output logic [IDX_W-1:0]    desc_count,
	output logic                last
);

	localparam longint LIM0    = (longint'(MAX_DESCS) - 1) * longint'(CHUNK_BYTES);
	localparam longint LIM1    = (longint'(MAX_DESCS) - 2) * longint'(CHUNK_BYTES);
	localparam longint LIM2    = (longint'(MAX_DESCS) - 3) * longint'(CHUNK_BYTES);
	localparam longint MID_CAP = longint'(1) << SIZE_W;
	localparam logic [SIZE_W:0] LIM0_W = (SIZE_W+1)'((LIM0 > MID_CAP) ? MID_CAP : LIM0);
	localparam logic [SIZE_W:0] LIM1_W = (SIZE_W+1)'((LIM1 > MID_CAP) ? MID_CAP : LIM1);
	localparam logic [SIZE_W:0] LIM2_W = (SIZE_W+1)'((LIM2 > MID_CAP) ? MID_CAP : LIM2);
	localparam logic            LIM2_NEG = (LIM2 < 0);
	localparam logic [SIZE_W-1:0] CHUNK_W = SIZE_W'(CHUNK_BYTES);

	logic [31:0]       head_bounce_q;
	logic [31:0]       tail_bounce_q;
	logic [31:0]       addr_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] mid_q;
	logic [31:0]       pos_q;
	logic [5:0]        head_q;
	logic [5:0]        tail_q;
	logic [IDX_W-1:0]  k_q;
	status_t           status_q;

	logic [5:0]        off;
	logic [5:0]        h_raw;
	logic [5:0]        head_n;
	logic [5:0]        endl;
	logic [5:0]        tail_n;
	logic [1:0]        nb;
	logic              over;
	logic              mid_more;
	logic [SIZE_W-1:0] chunk;
	logic [SIZE_W-1:0] bytes;
	logic [31:0]       tgt;
	logic              last_desc;
	logic              emit_req;
	logic              emit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_bounce_q <= '0;
			tail_bounce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				CFG_HEAD_BOUNCE: head_bounce_q <= cfg_wdata;
				CFG_TAIL_BOUNCE: tail_bounce_q <= cfg_wdata;
				default:         head_bounce_q <= head_bounce_q;
			endcase
		end
	end

	// head and tail split
	assign off    = addr_q[5:0];
	assign h_raw  = 6'(7'd64 - {1'b0, off});
	assign head_n = (off == 6'd0) ? 6'd0 :
		(({{(SIZE_W-6){1'b0}}, h_raw} > size_q) ? size_q[5:0] : h_raw);
	assign endl   = addr_q[5:0] + size_q[5:0];
	assign tail_n = (mid_q != '0 && endl != 6'd0) ?
		(({{(SIZE_W-6){1'b0}}, endl} > mid_q) ? mid_q[5:0] : endl) : 6'd0;

	// chain length check against the descriptor limit
	assign nb = {1'b0, head_q != 6'd0} + {1'b0, tail_q != 6'd0};
	always_comb begin
		unique case (nb)
			2'd0:    over = {1'b0, mid_q} > LIM0_W;
			2'd1:    over = {1'b0, mid_q} > LIM1_W;
			default: over = LIM2_NEG || ({1'b0, mid_q} > LIM2_W);
		endcase
	end

	assign mid_more = mid_q > CHUNK_W;
	assign chunk    = mid_more ? CHUNK_W : mid_q;

	always_comb begin
		unique case (ctrl.op)
			OP_EMIT_HEAD: begin
				bytes     = {{(SIZE_W-6){1'b0}}, head_q};
				tgt       = head_bounce_q;
				last_desc = (mid_q == '0) && (tail_q == 6'd0);
				emit_req  = head_q != 6'd0;
			end
			OP_EMIT_MID: begin
				bytes     = chunk;
				tgt       = pos_q;
				last_desc = !mid_more && (tail_q == 6'd0);
				emit_req  = mid_q != '0;
			end
			OP_EMIT_TAIL: begin
				bytes     = {{(SIZE_W-6){1'b0}}, tail_q};
				tgt       = tail_bounce_q;
				last_desc = 1'b1;
				emit_req  = tail_q != 6'd0;
			end
			OP_EMIT_DONE: begin
				bytes     = '0;
				tgt       = '0;
				last_desc = 1'b1;
				emit_req  = 1'b1;
			end
			default: begin
				bytes     = '0;
				tgt       = '0;
				last_desc = 1'b1;
				emit_req  = 1'b0;
			end
		endcase
	end

	assign emit = ctrl.go && emit_req;

	assign flags.in_valid   = in_valid;
	assign flags.size_zero  = size_q == '0;
	assign flags.misaligned = addr_q[1:0] != 2'd0;
	assign flags.over       = over;
	assign flags.mid_more   = mid_more;
	assign flags.blocked    = emit_req && out_valid && !out_ready;

	assign in_ready = ctrl.op == OP_LOAD;

	// request working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			status_q <= STS_OK;
		end else if (ctrl.go) begin
			unique case (ctrl.op)
				OP_LOAD: begin
					if (in_valid) begin
						k_q      <= '0;
						status_q <= STS_OK;
					end
				end
				OP_HEAD:  status_q <= (addr_q[1:0] != 2'd0) ? STS_MISALIGN : STS_OK;
				OP_LIMIT: status_q <= over ? STS_TOO_MANY : STS_OK;
				OP_EMIT_HEAD, OP_EMIT_MID, OP_EMIT_TAIL: begin
					if (emit_req) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			unique case (ctrl.op)
				OP_LOAD: begin
					if (in_valid) begin
						addr_q <= buffer_addr;
						size_q <= byte_count;
					end
				end
				OP_HEAD: begin
					head_q <= head_n;
					mid_q  <= size_q - {{(SIZE_W-6){1'b0}}, head_n};
				end
				OP_TAIL: begin
					tail_q <= tail_n;
					mid_q  <= mid_q - {{(SIZE_W-6){1'b0}}, tail_n};
					pos_q  <= addr_q + {26'd0, head_q};
				end
				OP_EMIT_MID: begin
					if (emit_req) begin
						mid_q <= mid_q - chunk;
						pos_q <= pos_q + {{(32-SIZE_W){1'b0}}, chunk};
					end
				end
				default: pos_q <= pos_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (ctrl.op == OP_EMIT_DONE) begin
				kind        <= 1'b1;
				desc_index  <= '0;
				target_addr <= '0;
				word_count  <= '0;
				attr_word   <= '0;
				status      <= status_q;
				desc_count  <= k_q;
				last        <= 1'b1;
			end else begin
				kind        <= 1'b0;
				desc_index  <= k_q;
				target_addr <= tgt;
				word_count  <= bytes[WC_W+1:2];
				attr_word   <= ATTR_VALID | (last_desc ? 16'h0 : ATTR_CONT) |
					{13'd0, align_code(bytes)};
				status      <= STS_OK;
				desc_count  <= '0;
				last        <= 1'b0;
			end
		end
	end

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken before chain finished");

	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind && status != STS_OK) |-> desc_count == '0)
		else $error("error completion with nonzero count");

	a_desc_attr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (attr_word[15] && !last))
		else $error("descriptor without valid attribute");

endmodule

### src/dma_descriptor_chain_builder_unit.sv
// ----------------------------------------------------------------------------
// dma_descriptor_chain_builder_unit
// Builds a scatter-gather descriptor chain for one transfer request.
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes the head (index 0) and tail (index 1) bounce buffer
//   addresses; cfg_ready is always high, write only while idle.
//   in channel takes one request (buffer_addr, byte_count). the out channel
//   returns the descriptors in chain order, then one completion transaction
//   with last high carrying status and descriptor count.
//   sequence: a microcoded sequencer walks one step per cycle while no result
//   is held back. a request is accepted at the load step and four check steps
//   follow; the head, middle and tail steps then run even when they emit
//   nothing, the middle step repeating once per extra chunk, and the
//   completion step comes last. zero-length, misaligned and too-many
//   requests jump from their check step straight to the completion step.
//   one request is in work at a time; in_ready is high only at the load step.
//   results sit in an output register: while a result waits there with
//   out_ready low, a step that emits a result holds the step counter, and a
//   new request may be accepted while the completion still waits.
//   reset clears the bounce addresses to zero and returns to the load step.
// ----------------------------------------------------------------------------
module dma_descriptor_chain_builder_unit
	import dcb_pkg::*;
#(
	parameter int unsigned MAX_DESCS   = DEF_MAX_DESCS,
	parameter int unsigned CHUNK_BYTES = DEF_CHUNK_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       buffer_addr,
	input  logic [SIZE_W-1:0] byte_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              kind,
	output logic [IDX_W-1:0]  desc_index,
	output logic [31:0]       target_addr,
	output logic [WC_W-1:0]   word_count,
	output logic [15:0]       attr_word,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  desc_count,
	output logic              last
);

	dp_flags_t flags;
	dp_ctrl_t  ctrl;

	assign cfg_ready = 1'b1;

	dcb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	dcb_dpath #(
		.MAX_DESCS   (MAX_DESCS),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.flags       (flags),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_sel     (cfg_index),
		.cfg_wdata   (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.buffer_addr (buffer_addr),
		.byte_count  (byte_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.desc_index  (desc_index),
		.target_addr (target_addr),
		.word_count  (word_count),
		.attr_word   (attr_word),
		.status      (status),
		.desc_count  (desc_count),
		.last        (last)
	);

endmodule

### sim/dma_descriptor_chain_builder_unit_tb.sv
// ----------------------------------------------------------------------------
// dma_descriptor_chain_builder_unit_tb
// Checks the descriptor chain builder against a built-in chain predictor.
// Requests are sent with directed corner cases, then random ones, over
// several idle and stall patterns and several bounce buffer settings.
// Every result transaction is compared in order with the predicted chain.
// ----------------------------------------------------------------------------
module dma_descriptor_chain_builder_unit_tb;
	import dcb_pkg::*;

	localparam int unsigned CHUNK       = DEF_CHUNK_BYTES;
	localparam int unsigned DESC_LIMIT  = DEF_MAX_DESCS;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned SETTLE_CYC  = 16;
	localparam int unsigned MAX_PRINTS  = 100;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  desc_index;
		logic [31:0]       target_addr;
		logic [WC_W-1:0]   word_count;
		logic [15:0]       attr_word;
		status_t           status;
		logic [IDX_W-1:0]  desc_count;
		logic              last;
	} chain_item_t;

	class chain_tracker;
		chain_item_t pending_items[$];
		logic [31:0] head_bounce;
		logic [31:0] tail_bounce;
		int unsigned mismatches;
		int unsigned checked;

		function new();
			head_bounce = '0;
			tail_bounce = '0;
			mismatches  = 0;
			checked     = 0;
		endfunction

		function void set_bounce(logic idx, logic [31:0] value);
			if (idx == CFG_HEAD_BOUNCE) begin
				head_bounce = value;
			end else begin
				tail_bounce = value;
			end
		endfunction

		function logic [2:0] grain(int unsigned bytes);
			if (bytes % 64 == 0) return ALIGN_64;
			if (bytes % 32 == 0) return ALIGN_32;
			if (bytes % 16 == 0) return ALIGN_16;
			return ALIGN_NONE;
		endfunction

		function void push_desc(int unsigned k, logic [31:0] target, int unsigned bytes,
				int unsigned total);
			chain_item_t d;
			d             = '0;
			d.desc_index  = k[IDX_W-1:0];
			d.target_addr = target;
			d.word_count  = WC_W'(bytes >> 2);
			d.attr_word   = ATTR_VALID | {13'd0, grain(bytes)};
			if (k + 1 != total) d.attr_word = d.attr_word | ATTR_CONT;
			pending_items.push_back(d);
		endfunction

		function void push_done(status_t s, int unsigned n);
			chain_item_t d;
			d            = '0;
			d.kind       = 1'b1;
			d.status     = s;
			d.desc_count = n[IDX_W-1:0];
			d.last       = 1'b1;
			pending_items.push_back(d);
		endfunction

		// expected chain for one accepted request
		function void take_request(logic [31:0] addr, logic [SIZE_W-1:0] size);
			logic [31:0] end_addr;
			logic [31:0] pos;
			int unsigned head_len, tail_len, body, n_chunks, total, k, piece;
			if (size == 0) begin
				push_done(STS_OK, 0);
				return;
			end
			if (addr[1:0] != 2'b00) begin
				push_done(STS_MISALIGN, 0);
				return;
			end
			end_addr = addr + 32'(size);
			head_len = 0;
			tail_len = 0;
			if (addr[5:0] != 6'd0) head_len = 64 - int'(addr[5:0]);
			if (head_len > size) head_len = 32'(size);
			body = size - head_len;
			if (body > 0 && end_addr[5:0] != 6'd0) tail_len = 32'(end_addr[5:0]);
			if (tail_len > body) tail_len = body;
			body = body - tail_len;
			n_chunks = (body + CHUNK - 1) / CHUNK;
			total = (head_len > 0 ? 1 : 0) + n_chunks + (tail_len > 0 ? 1 : 0);
			if (total >= DESC_LIMIT) begin
				push_done(STS_TOO_MANY, 0);
				return;
			end
			k = 0;
			if (head_len > 0) begin
				push_desc(k, head_bounce, head_len, total);
				k++;
			end
			pos = addr + head_len;
			while (body > 0) begin
				piece = body < CHUNK ? body : CHUNK;
				push_desc(k, pos, piece, total);
				k++;
				pos  = pos + piece;
				body = body - piece;
			end
			if (tail_len > 0) begin
				push_desc(k, tail_bounce, tail_len, total);
				k++;
			end
			push_done(STS_OK, k);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < MAX_PRINTS) $display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task match_result(chain_item_t got);
			chain_item_t want;
			string bad;
			checked++;
			if (pending_items.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected: %h", checked, got));
				return;
			end
			want = pending_items.pop_front();
			bad  = "";
			if (got.kind !== want.kind) bad = {bad, " kind"};
			if (got.desc_index !== want.desc_index) bad = {bad, " desc_index"};
			if (got.target_addr !== want.target_addr) bad = {bad, " target_addr"};
			if (got.word_count !== want.word_count) bad = {bad, " word_count"};
			if (got.attr_word !== want.attr_word) bad = {bad, " attr_word"};
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.desc_count !== want.desc_count) bad = {bad, " desc_count"};
			if (got.last !== want.last) bad = {bad, " last"};
			if (bad != "") begin
				report_mismatch($sformatf("result %0d bad%s: got %h want %h",
					checked, bad, got, want));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [31:0]       cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [31:0]       buffer_addr;
	logic [SIZE_W-1:0] byte_count;
	logic              out_valid;
	logic              out_ready;
	logic              kind;
	logic [IDX_W-1:0]  desc_index;
	logic [31:0]       target_addr;
	logic [WC_W-1:0]   word_count;
	logic [15:0]       attr_word;
	logic [1:0]        status;
	logic [IDX_W-1:0]  desc_count;
	logic              last;

	chain_tracker tracker;
	int unsigned  send_idle_pct;
	int unsigned  stall_pct;
	int unsigned  quiet_cycles;

	dma_descriptor_chain_builder_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.buffer_addr (buffer_addr),
		.byte_count  (byte_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.desc_index  (desc_index),
		.target_addr (target_addr),
		.word_count  (word_count),
		.attr_word   (attr_word),
		.status      (status),
		.desc_count  (desc_count),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		chain_item_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{kind, desc_index, target_addr, word_count, attr_word,
					status_t'(status), desc_count, last};
				tracker.match_result(got);
			end
			if (in_valid && in_ready) tracker.take_request(buffer_addr, byte_count);
			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("dma_descriptor_chain_builder_unit verification failed");
				$finish;
			end
		end
	end

	task automatic write_bounce(input logic idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_bounce(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_request(input logic [31:0] a, input logic [SIZE_W-1:0] n);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		buffer_addr <= a;
		byte_count  <= n;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_items.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic directed_requests();
		send_request(32'h0000_0000, 24'd0);
		send_request(32'h0000_0003, 24'd0);
		send_request(32'h0000_0001, 24'd100);
		send_request(32'h0000_0002, 24'hFF_FFFF);
		send_request(32'h0000_1000, 24'd4);
		send_request(32'h0000_1000, 24'd3);
		send_request(32'h0000_1000, 24'd64);
		send_request(32'h0000_1004, 24'd8);
		send_request(32'h0000_0010, 24'd16);
		send_request(32'h0000_1010, 24'd144);
		send_request(32'hFFFF_FFF0, 24'h100);
		send_request(32'hFFFF_FFFC, 24'hFF_FFFF);
		send_request(32'h0000_0000, 24'hFF_FFFF);
		send_request(32'h0000_0000, 24'(63 * CHUNK));
		send_request(32'h0000_0000, 24'(63 * CHUNK + 64));
		send_request(32'h0000_0020, 24'(62 * CHUNK + 32));
		send_request(32'h0000_0024, 24'(61 * CHUNK + 68));
		send_request(32'h0000_003C, 24'(2 * CHUNK + 1));
		send_request(32'h0000_0040, 24'(CHUNK));
		send_request(32'h8000_0000, 24'h80_0000);
		send_request(32'hAAAA_AAA8, 24'h55_5555);
	endtask

	task automatic random_request();
		int unsigned pick;
		logic [31:0] a;
		logic [SIZE_W-1:0] n;
		pick = $urandom_range(99);
		a    = $urandom() & 32'hFFFF_FFFC;
		if ($urandom_range(9) == 0) a[31:8] = 24'hFF_FFFF;
		if (pick < 10) begin
			a = $urandom();
			n = '0;
		end else if (pick < 20) begin
			a = $urandom() | 32'd1 << $urandom_range(1);
			n = SIZE_W'($urandom());
		end else if (pick < 80) begin
			n = SIZE_W'($urandom_range(2000, 1));
		end else if (pick < 92) begin
			n = SIZE_W'($urandom_range(4 * CHUNK, 1));
		end else begin
			n = SIZE_W'($urandom());
		end
		send_request(a, n);
	endtask

	initial begin
		int unsigned idle_by_phase[4];
		int unsigned stall_by_phase[4];
		logic [31:0] head_by_phase[4];
		logic [31:0] tail_by_phase[4];
		idle_by_phase  = '{0, 79, 0, 19};
		stall_by_phase = '{0, 0, 79, 19};
		head_by_phase  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom() & 32'hFFFF_FFC0, $urandom()};
		tail_by_phase  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom() & 32'hFFFF_FFC0, $urandom()};
		tracker       = new();
		send_idle_pct = 0;
		stall_pct     = 0;
		quiet_cycles  = 0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_HEAD_BOUNCE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		buffer_addr   = '0;
		byte_count    = '0;
		out_ready     = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 4; p++) begin
			settle();
			write_bounce(CFG_HEAD_BOUNCE, head_by_phase[p]);
			write_bounce(CFG_TAIL_BOUNCE, tail_by_phase[p]);
			send_idle_pct = idle_by_phase[p];
			stall_pct     = stall_by_phase[p];
			if (p == 0) directed_requests();
			repeat (25) random_request();
		end
		settle();
		if (tracker.pending_items.size() != 0) begin
			tracker.report_mismatch("results still expected at end of run");
		end
		if (tracker.mismatches == 0) begin
			$display("dma_descriptor_chain_builder_unit verification clean");
		end else begin
			$display("dma_descriptor_chain_builder_unit verification failed");
		end
		$finish;
	end

endmodule
